/* rtl/cpu8_pkg.sv */
// Package for the 8-bit CPU subset execute unit: types, opcodes and codes.
// Used by the interfaces and by every module of the unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cpu8_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;

  typedef enum logic [1:0] {
    BUS_READ  = 2'd0,
    BUS_WRITE = 2'd1,
    BUS_FAULT = 2'd2
  } bus_op_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FETCH = 3'd1,
    PH_OP1   = 3'd2,
    PH_OP2   = 3'd3,
    PH_LOAD  = 3'd4
  } phase_e;

  localparam logic [7:0] OpNop   = 8'h00;
  localparam logic [7:0] OpMviB  = 8'h06;
  localparam logic [7:0] OpLxiD  = 8'h11;
  localparam logic [7:0] OpLdaxD = 8'h1A;
  localparam logic [7:0] OpLxiH  = 8'h21;
  localparam logic [7:0] OpInxH  = 8'h23;
  localparam logic [7:0] OpLxiSp = 8'h31;
  localparam logic [7:0] OpMovMA = 8'h77;
  localparam logic [7:0] OpJmp   = 8'hC3;
  localparam logic [7:0] OpCall  = 8'hCD;

  // One input word as it enters the unit.
  typedef struct packed {
    logic             func;
    logic [DataW-1:0] read_data;
  } in_word_t;

  // One bus request word as it leaves the unit.
  typedef struct packed {
    bus_op_e          bus_op;
    logic [AddrW-1:0] bus_address;
    logic [DataW-1:0] write_data;
    logic             last;
  } out_word_t;

endpackage
`default_nettype wire

/* rtl/cpu8_in_if.sv */
// Valid/ready channel carrying input words into the execute unit.
// Depends on cpu8_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cpu8_in_if;
  logic             valid;
  logic             ready;
  logic             func;
  logic [cpu8_pkg::DataW-1:0] read_data;

  modport source (output valid, output func, output read_data, input ready);
  modport sink (input valid, input func, input read_data, output ready);
endinterface
`default_nettype wire

/* rtl/cpu8_out_if.sv */
// Valid/ready channel carrying bus request words out of the execute unit.
// Depends on cpu8_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cpu8_out_if;
  logic                       valid;
  logic                       ready;
  cpu8_pkg::bus_op_e          bus_op;
  logic [cpu8_pkg::AddrW-1:0] bus_address;
  logic [cpu8_pkg::DataW-1:0] write_data;
  logic                       last;

  modport source (output valid, output bus_op, output bus_address, output write_data,
                  output last, input ready);
  modport sink (input valid, input bus_op, input bus_address, input write_data,
                input last, output ready);
endinterface
`default_nettype wire

/* rtl/cpu8_cfg_if.sv */
// Valid/ready write channel for the start address register.
// Depends on cpu8_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cpu8_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cpu8_pkg::AddrW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/cpu8_front.sv */
// Front end: accepts input words and holds them in a two-entry queue.
// Depends on cpu8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpu8_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  cpu8_pkg::in_word_t   in_word_i,
  output logic                 q_valid_o,
  input  wire                  q_pop_i,
  output cpu8_pkg::in_word_t   q_word_o
);

  cpu8_pkg::in_word_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_word_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad fill count");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

/* rtl/cpu8_back.sv */
// Back end: the phase machine with the register file; emits up to three
// bus request words per input word, one per cycle while the output is ready. Depends on cpu8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpu8_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [cpu8_pkg::AddrW-1:0] start_addr_i,
  input  wire                  q_valid_i,
  output logic                 q_pop_o,
  input  cpu8_pkg::in_word_t   q_word_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output cpu8_pkg::out_word_t  out_word_o
);

  // Registers of the CPU.
  logic [15:0] pc_q, pc_d, sp_q, sp_d, de_q, de_d, hl_q, hl_d;
  logic [7:0]  acc_q, acc_d, b_q, b_d, opc_q, opc_d, lo_q, lo_d;
  logic        halt_q, halt_d;
  cpu8_pkg::phase_e ph_q, ph_d;

  // Pending request words: up to three, issued from slot 0 upward.
  cpu8_pkg::out_word_t slot_q [3];
  cpu8_pkg::out_word_t slot_d [3];
  logic [1:0] n_q, n_d, idx_q, idx_d;

  logic busy, take_out, consume;
  logic [15:0] word, pc_inc;

  cpu8_pkg::out_word_t fetch_w;

  assign busy     = (idx_q != n_q);
  assign out_valid_o = busy;
  assign out_word_o  = slot_q[idx_q];
  assign take_out = busy && out_ready_i;
  // A new word may be consumed once the last pending request leaves.
  assign consume  = q_valid_i && (!busy || (take_out && idx_q == n_q - 2'd1));
  assign q_pop_o  = consume;
  assign word     = {q_word_i.read_data, lo_q};
  assign pc_inc   = pc_q + 16'd1;

  function automatic cpu8_pkg::out_word_t mk(cpu8_pkg::bus_op_e op, logic [15:0] a,
                                             logic [7:0] d, logic l);
    cpu8_pkg::out_word_t w;
    w.bus_op = op; w.bus_address = a; w.write_data = d; w.last = l;
    return w;
  endfunction

  // Next-state and request generation for one consumed input word.
  always_comb begin
    pc_d = pc_q; sp_d = sp_q; de_d = de_q; hl_d = hl_q;
    acc_d = acc_q; b_d = b_q; opc_d = opc_q; lo_d = lo_q;
    halt_d = halt_q; ph_d = ph_q;
    slot_d = slot_q; n_d = n_q;
    idx_d = take_out ? idx_q + 2'd1 : idx_q;
    fetch_w = mk(cpu8_pkg::BUS_READ, pc_q, 8'd0, 1'b1);
    if (consume) begin
      idx_d = 2'd0;
      n_d   = 2'd0;
      if (!q_word_i.func) begin
        halt_d = 1'b0;
        pc_d   = start_addr_i;
        ph_d   = cpu8_pkg::PH_FETCH;
        slot_d[0] = mk(cpu8_pkg::BUS_READ, start_addr_i, 8'd0, 1'b1);
        n_d = 2'd1;
      end else if (!halt_q) begin
        unique case (ph_q)
          cpu8_pkg::PH_FETCH: begin
            opc_d = q_word_i.read_data;
            pc_d  = pc_inc;
            fetch_w = mk(cpu8_pkg::BUS_READ, pc_inc, 8'd0, 1'b1);
            unique case (q_word_i.read_data) inside
              cpu8_pkg::OpMviB, cpu8_pkg::OpLxiD, cpu8_pkg::OpLxiH,
              cpu8_pkg::OpLxiSp, cpu8_pkg::OpJmp, cpu8_pkg::OpCall: begin
                ph_d = cpu8_pkg::PH_OP1;
                slot_d[0] = fetch_w; n_d = 2'd1;
              end
              cpu8_pkg::OpNop: begin
                slot_d[0] = fetch_w; n_d = 2'd1;
              end
              cpu8_pkg::OpLdaxD: begin
                ph_d = cpu8_pkg::PH_LOAD;
                slot_d[0] = mk(cpu8_pkg::BUS_READ, de_q, 8'd0, 1'b1); n_d = 2'd1;
              end
              cpu8_pkg::OpInxH: begin
                hl_d = hl_q + 16'd1;
                slot_d[0] = fetch_w; n_d = 2'd1;
              end
              cpu8_pkg::OpMovMA: begin
                slot_d[0] = mk(cpu8_pkg::BUS_WRITE, hl_q, acc_q, 1'b0);
                slot_d[1] = fetch_w; n_d = 2'd2;
              end
              default: begin
                halt_d = 1'b1;
                ph_d   = cpu8_pkg::PH_IDLE;
                slot_d[0] = mk(cpu8_pkg::BUS_FAULT, pc_q, 8'd0, 1'b1); n_d = 2'd1;
              end
            endcase
          end
          cpu8_pkg::PH_OP1: begin
            lo_d = q_word_i.read_data;
            pc_d = pc_inc;
            if (opc_q == cpu8_pkg::OpMviB) begin
              b_d = q_word_i.read_data;
              ph_d = cpu8_pkg::PH_FETCH;
            end else begin
              ph_d = cpu8_pkg::PH_OP2;
            end
            slot_d[0] = mk(cpu8_pkg::BUS_READ, pc_inc, 8'd0, 1'b1); n_d = 2'd1;
          end
          cpu8_pkg::PH_OP2: begin
            ph_d = cpu8_pkg::PH_FETCH;
            pc_d = pc_inc;
            fetch_w = mk(cpu8_pkg::BUS_READ, pc_inc, 8'd0, 1'b1);
            slot_d[0] = fetch_w; n_d = 2'd1;
            unique case (opc_q)
              cpu8_pkg::OpLxiD:  de_d = word;
              cpu8_pkg::OpLxiH:  hl_d = word;
              cpu8_pkg::OpLxiSp: sp_d = word;
              cpu8_pkg::OpJmp: begin
                pc_d = word;
                slot_d[0] = mk(cpu8_pkg::BUS_READ, word, 8'd0, 1'b1);
              end
              default: begin
                sp_d = sp_q - 16'd2;
                pc_d = word;
                slot_d[0] = mk(cpu8_pkg::BUS_WRITE, sp_q - 16'd2, pc_inc[7:0], 1'b0);
                slot_d[1] = mk(cpu8_pkg::BUS_WRITE, sp_q - 16'd1, pc_inc[15:8], 1'b0);
                slot_d[2] = mk(cpu8_pkg::BUS_READ, word, 8'd0, 1'b1);
                n_d = 2'd3;
              end
            endcase
          end
          cpu8_pkg::PH_LOAD: begin
            acc_d = q_word_i.read_data;
            ph_d  = cpu8_pkg::PH_FETCH;
            slot_d[0] = fetch_w; n_d = 2'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; sp_q <= '0; de_q <= '0; hl_q <= '0;
      acc_q <= '0; b_q <= '0; opc_q <= '0; lo_q <= '0;
      halt_q <= 1'b0; ph_q <= cpu8_pkg::PH_IDLE;
      n_q <= '0; idx_q <= '0;
    end else begin
      pc_q <= pc_d; sp_q <= sp_d; de_q <= de_d; hl_q <= hl_d;
      acc_q <= acc_d; b_q <= b_d; opc_q <= opc_d; lo_q <= lo_d;
      halt_q <= halt_d; ph_q <= ph_d;
      n_q <= n_d; idx_q <= idx_d;
    end
  end

  // Request payload slots.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

`ifndef SYNTH
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= n_q) else $error("issue index beyond pending count");
  a_halt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> ph_q == cpu8_pkg::PH_IDLE) else $error("halted but not idle");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.last == (idx_q == n_q - 2'd1)))
    else $error("last flag misplaced");
`endif

endmodule
`default_nettype wire

/* rtl/cpu8_subset_execute_unit_top.sv */
// Execute unit top: input queue, phase machine, start address register.
// An input word is registered in the queue, then in the request slots.
// Throughput: one input word every cycle while the output is ready, when it
// causes one request; a word causing n requests holds the next word back.
// Reset: asynchronous, active low; all CPU registers clear and the unit idles.
// Depends on cpu8_pkg, the channel interfaces, cpu8_front and cpu8_back.
`timescale 1ns / 1ps
`default_nettype none
module cpu8_subset_execute_unit_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  cpu8_in_if.sink    in_i,
  cpu8_out_if.source out_o,
  cpu8_cfg_if.sink   cfg_i
);

  logic [cpu8_pkg::AddrW-1:0] start_q;
  cpu8_pkg::in_word_t  in_w, q_w;
  cpu8_pkg::out_word_t o_w;
  logic q_valid, q_pop;

  assign cfg_i.ready = 1'b1;

  // Start address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_i.valid) begin
      start_q <= cfg_i.data;
    end
  end

  assign in_w.func      = in_i.func;
  assign in_w.read_data = in_i.read_data;

  cpu8_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid), .in_ready_o (in_i.ready), .in_word_i (in_w),
    .q_valid_o (q_valid), .q_pop_i (q_pop), .q_word_o (q_w)
  );

  cpu8_back u_back (
    .clk_i, .rst_ni, .start_addr_i (start_q),
    .q_valid_i (q_valid), .q_pop_o (q_pop), .q_word_i (q_w),
    .out_valid_o (out_o.valid), .out_ready_i (out_o.ready), .out_word_o (o_w)
  );

  assign out_o.bus_op      = o_w.bus_op;
  assign out_o.bus_address = o_w.bus_address;
  assign out_o.write_data  = o_w.write_data;
  assign out_o.last        = o_w.last;

endmodule
`default_nettype wire
